// ===== src/lcrm_pkg.sv =====
// Shared types, codes and helpers of the link connect/retry manager.
// Used by the front, command queue, back, top level and checker; no dependencies.
`default_nettype none

package lcrm_pkg;

  localparam logic [2:0] OP_SEND         = 3'd0;
  localparam logic [2:0] OP_CONNECT_DONE = 3'd1;
  localparam logic [2:0] OP_WRITE_DONE   = 3'd2;
  localparam logic [2:0] OP_TICK         = 3'd3;
  localparam logic [2:0] OP_STOP         = 3'd4;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FAILED   = 2'd1;
  localparam logic [1:0] STATUS_CANCELED = 2'd2;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_DONE    = 2'd1;
  localparam logic [1:0] ACT_CONNECT = 2'd2;
  localparam logic [1:0] ACT_CLOSE   = 2'd3;

  localparam logic [1:0] DS_OK       = 2'd0;
  localparam logic [1:0] DS_IO       = 2'd1;
  localparam logic [1:0] DS_CANCELED = 2'd2;
  localparam logic [1:0] DS_CONNFAIL = 2'd3;

  localparam logic [2:0] LINK_IDLE       = 3'd0;
  localparam logic [2:0] LINK_CONNECTING = 3'd1;
  localparam logic [2:0] LINK_CONNECTED  = 3'd2;
  localparam logic [2:0] LINK_DELAY      = 3'd3;
  localparam logic [2:0] LINK_CLOSING    = 3'd4;
  localparam logic [2:0] LINK_CLOSED     = 3'd5;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_RETRY_DELAY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WARN_AFTER  = 2'd1;

  localparam logic [31:0] RETRY_DELAY_RESET = 32'd1000;
  localparam logic [15:0] WARN_AFTER_RESET  = 16'd10;

  localparam int unsigned CMD_QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_SEND,
    CMD_CONN_OK,
    CMD_CONN_FAIL,
    CMD_WR_OK,
    CMD_WR_FAIL,
    CMD_WR_CANCEL,
    CMD_TICK,
    CMD_STOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] tag;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] tag;
    logic [1:0] done_status;
    logic       warn;
  } result_t;

  function automatic result_t make_result(input logic [1:0] action, input logic [7:0] tag,
                                          input logic [1:0] done_status, input logic warn);
    result_t r;
    r.action      = action;
    r.tag         = tag;
    r.done_status = done_status;
    r.warn        = warn;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/lcrm_front.sv =====
// Front end: registers each event with a known opcode, classified into a command.
// Depends on lcrm_pkg; feeds lcrm_cmd_queue.
`default_nettype none

module lcrm_front import lcrm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] in_opcode_i,
  input  wire logic [7:0] in_request_tag_i,
  input  wire logic [1:0] in_status_i,
  output logic            q_push_o,
  output cmd_t            q_cmd_o,
  input  wire logic       q_full_i
);

  cmd_kind_e kind;
  logic      accept;
  logic      cmd_v_q, cmd_v_d;
  cmd_t      cmd_q, cmd_d;

  always_comb begin
    case (in_opcode_i)
      OP_SEND: kind = CMD_SEND;
      OP_CONNECT_DONE: kind = (in_status_i == STATUS_OK) ? CMD_CONN_OK : CMD_CONN_FAIL;
      OP_WRITE_DONE: begin
        if (in_status_i == STATUS_OK) begin
          kind = CMD_WR_OK;
        end else if (in_status_i == STATUS_CANCELED) begin
          kind = CMD_WR_CANCEL;
        end else begin
          kind = CMD_WR_FAIL;
        end
      end
      OP_TICK: kind = CMD_TICK;
      OP_STOP: kind = CMD_STOP;
      default: kind = CMD_NONE;
    endcase
  end

  assign in_stall_o = cmd_v_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = cmd_v_q && !q_full_i;
  assign q_cmd_o    = cmd_q;

  always_comb begin
    cmd_v_d = (cmd_v_q && q_full_i) || (accept && (kind != CMD_NONE));
    cmd_d   = cmd_q;
    if (accept) begin
      cmd_d.kind = kind;
      cmd_d.tag  = in_request_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_v_q <= 1'b0;
      cmd_q   <= '0;
    end else begin
      cmd_v_q <= cmd_v_d;
      cmd_q   <= cmd_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/lcrm_cmd_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on lcrm_pkg for the command type and depth.
`default_nettype none

module lcrm_cmd_queue import lcrm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      head_cmd_o
);

  localparam int unsigned PW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMD_QUEUE_DEPTH + 1);

  cmd_t            mem_q [CMD_QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    logic [PW-1:0] n;
    if (p == PW'(CMD_QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  assign full_o     = (count_q == CW'(CMD_QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign head_cmd_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/lcrm_back.sv =====
// Back end: owns link state, pending tag FIFO, counters and configuration, plans each
// command and emits its results one per cycle while not stalled. Depends on lcrm_pkg.
`default_nettype none

module lcrm_back import lcrm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [31:0]            cfg_data_i,
  input  wire logic                   q_empty_i,
  input  cmd_t                        q_cmd_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output result_t                     out_result_o,
  output logic [2:0]                  out_link_state_o,
  output logic                        out_last_o
);

  localparam int unsigned QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QSW = QCW + 1;

  typedef enum logic {B_IDLE, B_RUN} back_state_e;

  back_state_e    state_q, state_d;
  logic [2:0]     link_q, link_d;
  logic [15:0]    attempt_q, attempt_d;
  logic [31:0]    delay_q, delay_d;
  logic [QIW-1:0] head_q, head_d;
  logic [QCW-1:0] count_q, count_d;
  logic [31:0]    retry_delay_q, retry_delay_d;
  logic [15:0]    warn_after_q, warn_after_d;

  logic           pre0_v_q, pre0_v_d, pre1_v_q, pre1_v_d, post_v_q, post_v_d;
  logic           drain_v_q, drain_v_d;
  result_t        pre0_q, pre0_d, pre1_q, pre1_d, post_q, post_d;
  logic [1:0]     drain_act_q, drain_act_d, drain_ds_q, drain_ds_d;

  logic           out_v_q, out_v_d, out_last_q, out_last_d;
  result_t        out_res_q, out_res_d;
  logic [2:0]     out_link_q, out_link_d;

  logic [7:0]     tags_q [QUEUE_DEPTH];
  logic           tag_we;
  logic [QIW-1:0] tag_waddr;
  logic [QSW-1:0] push_sum;
  logic [QIW-1:0] push_idx;
  logic           queue_full;
  logic [7:0]     head_tag;
  logic [15:0]    attempt_inc;
  logic           delay_expired;
  logic           warn_hit;

  function automatic logic [QIW-1:0] index_next(input logic [QIW-1:0] idx);
    logic [QIW-1:0] n;
    if (idx == QIW'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = idx + 1'b1;
    end
    return n;
  endfunction

  always_comb begin
    push_sum = QSW'(head_q) + QSW'(count_q);
    if (push_sum >= QSW'(QUEUE_DEPTH)) begin
      push_sum = push_sum - QSW'(QUEUE_DEPTH);
    end
    push_idx = push_sum[QIW-1:0];
  end

  assign queue_full    = (count_q == QCW'(QUEUE_DEPTH));
  assign head_tag      = tags_q[head_q];
  assign attempt_inc   = (attempt_q == 16'hFFFF) ? attempt_q : attempt_q + 16'd1;
  assign delay_expired = (delay_q[31:1] == '0);
  assign warn_hit      = (attempt_q >= warn_after_q);

  always_comb begin
    state_d       = state_q;
    link_d        = link_q;
    attempt_d     = attempt_q;
    delay_d       = delay_q;
    head_d        = head_q;
    count_d       = count_q;
    retry_delay_d = retry_delay_q;
    warn_after_d  = warn_after_q;
    pre0_v_d      = pre0_v_q;
    pre1_v_d      = pre1_v_q;
    post_v_d      = post_v_q;
    drain_v_d     = drain_v_q;
    pre0_d        = pre0_q;
    pre1_d        = pre1_q;
    post_d        = post_q;
    drain_act_d   = drain_act_q;
    drain_ds_d    = drain_ds_q;
    out_v_d       = out_v_q && out_stall_i;
    out_res_d     = out_res_q;
    out_link_d    = out_link_q;
    out_last_d    = out_last_q;
    q_pop_o       = 1'b0;
    tag_we        = 1'b0;
    tag_waddr     = push_idx;

    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_RETRY_DELAY: retry_delay_d = cfg_data_i;
        REG_WARN_AFTER: warn_after_d = cfg_data_i[15:0];
        default: ;
      endcase
    end

    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.kind)
            CMD_SEND: begin
              if (link_q == LINK_CONNECTED) begin
                pre0_v_d = 1'b1;
                pre0_d   = make_result(ACT_WRITE, q_cmd_i.tag, DS_OK, 1'b0);
              end else if (link_q == LINK_CLOSING || link_q == LINK_CLOSED) begin
                pre0_v_d = 1'b1;
                pre0_d   = make_result(ACT_DONE, q_cmd_i.tag, DS_CANCELED, 1'b0);
              end else begin
                if (link_q == LINK_IDLE) begin
                  link_d    = LINK_CONNECTING;
                  attempt_d = attempt_inc;
                  pre0_v_d  = 1'b1;
                  pre0_d    = make_result(ACT_CONNECT, 8'd0, DS_OK, 1'b0);
                end
                tag_we = 1'b1;
                if (queue_full) begin
                  if (link_q == LINK_IDLE) begin
                    pre1_v_d = 1'b1;
                    pre1_d   = make_result(ACT_DONE, head_tag, DS_CONNFAIL, 1'b0);
                  end else begin
                    pre0_v_d = 1'b1;
                    pre0_d   = make_result(ACT_DONE, head_tag, DS_CONNFAIL, 1'b0);
                  end
                  tag_waddr = head_q;
                  head_d    = index_next(head_q);
                end else begin
                  count_d = count_q + 1'b1;
                end
              end
            end
            CMD_CONN_OK, CMD_CONN_FAIL: begin
              if (link_q == LINK_CLOSING) begin
                link_d = LINK_CLOSED;
              end else if (link_q == LINK_CONNECTING) begin
                if (q_cmd_i.kind == CMD_CONN_OK) begin
                  link_d      = LINK_CONNECTED;
                  attempt_d   = '0;
                  drain_v_d   = (count_q != '0);
                  drain_act_d = ACT_WRITE;
                  drain_ds_d  = DS_OK;
                end else begin
                  link_d  = LINK_DELAY;
                  delay_d = retry_delay_q;
                end
              end
            end
            CMD_WR_OK: begin
              pre0_v_d = 1'b1;
              pre0_d   = make_result(ACT_DONE, q_cmd_i.tag, DS_OK, 1'b0);
            end
            CMD_WR_FAIL, CMD_WR_CANCEL: begin
              if (link_q == LINK_CONNECTED) begin
                link_d    = LINK_CONNECTING;
                attempt_d = attempt_inc;
                pre0_v_d  = 1'b1;
                pre0_d    = make_result(ACT_CLOSE, 8'd0, DS_OK, 1'b0);
                pre1_v_d  = 1'b1;
                pre1_d    = make_result(ACT_CONNECT, 8'd0, DS_OK, 1'b0);
                post_v_d  = 1'b1;
                post_d    = make_result(ACT_DONE, q_cmd_i.tag, DS_IO, 1'b0);
              end else begin
                pre0_v_d = 1'b1;
                pre0_d   = make_result(ACT_DONE, q_cmd_i.tag,
                                       (q_cmd_i.kind == CMD_WR_CANCEL) ? DS_CANCELED : DS_IO,
                                       1'b0);
              end
            end
            CMD_TICK: begin
              if (link_q == LINK_DELAY) begin
                if (delay_expired) begin
                  delay_d   = '0;
                  link_d    = LINK_CONNECTING;
                  attempt_d = attempt_inc;
                  pre0_v_d  = 1'b1;
                  pre0_d    = make_result(ACT_CONNECT, 8'd0, DS_OK, warn_hit);
                end else begin
                  delay_d = delay_q - 32'd1;
                end
              end
            end
            CMD_STOP: begin
              if (link_q == LINK_CONNECTING || link_q == LINK_DELAY ||
                  link_q == LINK_CONNECTED) begin
                drain_v_d   = (count_q != '0);
                drain_act_d = ACT_DONE;
                drain_ds_d  = DS_CANCELED;
                delay_d     = '0;
                if (link_q == LINK_CONNECTED) begin
                  post_v_d = 1'b1;
                  post_d   = make_result(ACT_CLOSE, 8'd0, DS_OK, 1'b0);
                  link_d   = LINK_CLOSED;
                end else if (link_q == LINK_DELAY) begin
                  link_d = LINK_CLOSED;
                end else begin
                  link_d = LINK_CLOSING;
                end
              end else if (link_q == LINK_IDLE) begin
                link_d = LINK_CLOSED;
              end
            end
            default: ;
          endcase
          if (pre0_v_d || drain_v_d || post_v_d) begin
            state_d = B_RUN;
          end
        end
      end
      B_RUN: begin
        if (!out_v_q || !out_stall_i) begin
          out_v_d    = 1'b1;
          out_link_d = link_q;
          if (pre0_v_q) begin
            out_res_d  = pre0_q;
            pre0_v_d   = 1'b0;
            out_last_d = !(pre1_v_q || drain_v_q || post_v_q);
          end else if (pre1_v_q) begin
            out_res_d  = pre1_q;
            pre1_v_d   = 1'b0;
            out_last_d = !(drain_v_q || post_v_q);
          end else if (drain_v_q) begin
            out_res_d  = make_result(drain_act_q, head_tag, drain_ds_q, 1'b0);
            head_d     = index_next(head_q);
            count_d    = count_q - 1'b1;
            drain_v_d  = (count_q != QCW'(1));
            out_last_d = !((count_q != QCW'(1)) || post_v_q);
          end else begin
            out_res_d  = post_q;
            post_v_d   = 1'b0;
            out_last_d = 1'b1;
          end
          if (out_last_d) begin
            state_d = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= B_IDLE;
      link_q        <= LINK_IDLE;
      attempt_q     <= '0;
      delay_q       <= '0;
      head_q        <= '0;
      count_q       <= '0;
      retry_delay_q <= RETRY_DELAY_RESET;
      warn_after_q  <= WARN_AFTER_RESET;
      pre0_v_q      <= 1'b0;
      pre1_v_q      <= 1'b0;
      post_v_q      <= 1'b0;
      drain_v_q     <= 1'b0;
      pre0_q        <= '0;
      pre1_q        <= '0;
      post_q        <= '0;
      drain_act_q   <= '0;
      drain_ds_q    <= '0;
      out_v_q       <= 1'b0;
      out_res_q     <= '0;
      out_link_q    <= '0;
      out_last_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      link_q        <= link_d;
      attempt_q     <= attempt_d;
      delay_q       <= delay_d;
      head_q        <= head_d;
      count_q       <= count_d;
      retry_delay_q <= retry_delay_d;
      warn_after_q  <= warn_after_d;
      pre0_v_q      <= pre0_v_d;
      pre1_v_q      <= pre1_v_d;
      post_v_q      <= post_v_d;
      drain_v_q     <= drain_v_d;
      pre0_q        <= pre0_d;
      pre1_q        <= pre1_d;
      post_q        <= post_d;
      drain_act_q   <= drain_act_d;
      drain_ds_q    <= drain_ds_d;
      out_v_q       <= out_v_d;
      out_res_q     <= out_res_d;
      out_link_q    <= out_link_d;
      out_last_q    <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tags_q[tag_waddr] <= q_cmd_i.tag;
    end
  end

  assign out_valid_o      = out_v_q;
  assign out_result_o     = out_res_q;
  assign out_link_state_o = out_link_q;
  assign out_last_o       = out_last_q;

endmodule

`default_nettype wire

// ===== src/link_connect_retry_manager_top.sv =====
// An accepted item is registered in the front end and then written into the command queue,
// from which the back end takes it and plans its results; the results then leave through
// the output register one per cycle while the output is not stalled. The back end plans no
// new item until the current one's last result is in the output register; the front accepts
// one item per cycle until the two-entry command queue fills. Reset clears all control state
// at once: link idle, pending FIFO empty, retry_delay 1000, warn_after_attempts 10.
`default_nettype none

module link_connect_retry_manager_top import lcrm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [31:0]            cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [2:0]             in_opcode_i,
  input  wire logic [7:0]             in_request_tag_i,
  input  wire logic [1:0]             in_status_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [1:0]                  out_action_o,
  output logic [7:0]                  out_tag_o,
  output logic [1:0]                  out_done_status_o,
  output logic                        out_warn_o,
  output logic [2:0]                  out_link_state_o,
  output logic                        out_last_o
);

  logic    q_push, q_full, q_pop, q_empty;
  cmd_t    q_push_cmd, q_head_cmd;
  result_t out_result;

  assign cfg_ready_o = 1'b1;

  lcrm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_opcode_i      (in_opcode_i),
    .in_request_tag_i (in_request_tag_i),
    .in_status_i      (in_status_i),
    .q_push_o         (q_push),
    .q_cmd_o          (q_push_cmd),
    .q_full_i         (q_full)
  );

  lcrm_cmd_queue u_cmd_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_cmd_o (q_head_cmd)
  );

  lcrm_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .q_empty_i        (q_empty),
    .q_cmd_i          (q_head_cmd),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_result_o     (out_result),
    .out_link_state_o (out_link_state_o),
    .out_last_o       (out_last_o)
  );

  assign out_action_o      = out_result.action;
  assign out_tag_o         = out_result.tag;
  assign out_done_status_o = out_result.done_status;
  assign out_warn_o        = out_result.warn;

endmodule

`default_nettype wire

// ===== src/lcrm_checker.sv =====
// Port-level checks of the link connect/retry manager, bound to its top level.
// Depends on lcrm_pkg and link_connect_retry_manager_top.
`default_nettype none

module lcrm_checker import lcrm_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic [1:0]             out_action_o,
  input wire logic [7:0]             out_tag_o,
  input wire logic [1:0]             out_done_status_o,
  input wire logic                   out_warn_o,
  input wire logic [2:0]             out_link_state_o,
  input wire logic                   out_last_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_action_o) &&
      $stable(out_tag_o) && $stable(out_last_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_last_o |=> out_valid_o)
    else $error("gap inside a run of results");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_last_o |=>
      out_link_state_o == $past(out_link_state_o))
    else $error("link state differs within one item's results");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_action_o == ACT_CONNECT || out_action_o == ACT_CLOSE) |->
      out_tag_o == 8'd0 && out_done_status_o == DS_OK)
    else $error("connect or close result carries a tag or status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_warn_o |-> out_action_o == ACT_CONNECT)
    else $error("warn set on a result that is not a connect");

endmodule

bind link_connect_retry_manager_top lcrm_checker u_lcrm_checker (.*);

`default_nettype wire
